@@ rtl/core/farc_pkg.sv @@
`timescale 1ns / 1ps

package farc_pkg;

    localparam int KIND_W   = 2;
    localparam int ADDR_W   = 64;
    localparam int STATUS_W = 3;
    localparam int INDEX_W  = 6;

    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TRACK = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;

    localparam logic [STATUS_W-1:0] ST_EMPTY  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_INSIDE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_PAST   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BEFORE = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NONE   = 3'd4;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } state_t;

    typedef struct packed {
        logic busy;
        logic hit;
        logic found;
    } scan_flags_t;

endpackage

@@ rtl/core/fault_address_range_correlator_core.sv @@
`timescale 1ns / 1ps
// clear and track items leave the block idle; it is ready again the next cycle
// a query scans the stored regions, reading one region a cycle through a three-stage compare
// pipe, then drains the pipe and gives its result; an empty table skips the scan
// no item is taken while a query is in flight; the next can go in while the result is presented
// reset (aresetn low, synchronous) empties the table and drops any pending result;
// the region memory itself is not cleared

module fault_address_range_correlator_core #(
    parameter int ENTRIES = 64
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // address, region_size
    input  logic [1:0]   s_tuser,   // kind
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [199:0] m_tdata,   // entry_index, distance, entry_base, entry_length, zero pad
    output logic [2:0]   m_tuser    // status
);

    localparam int AW   = farc_pkg::ADDR_W;
    localparam int IDXW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW   = $clog2(ENTRIES + 1);
    localparam int IW   = farc_pkg::INDEX_W;

    farc_pkg::state_t state_reg, state_next;

    logic [CW-1:0]   count_reg, count_next;
    logic [IDXW-1:0] rd_idx_reg, rd_idx_next;
    logic [AW-1:0]   addr_reg, addr_next;
    logic            rd_en;
    logic            v0_reg;
    logic [IDXW-1:0] idx0_reg;
    logic [2*AW-1:0] rd_data_reg;
    logic [2*AW-1:0] mem [ENTRIES];
    logic            wr_en;
    logic            start;
    logic            in_fire;
    logic            last_issue;

    logic                          m_tvalid_reg, m_tvalid_next;
    logic [farc_pkg::STATUS_W-1:0] m_status_reg, m_status_next;
    logic [IW-1:0]                 m_index_reg, m_index_next;
    logic [AW-1:0]                 m_dist_reg, m_dist_next;
    logic [AW-1:0]                 m_base_reg, m_base_next;
    logic [AW-1:0]                 m_len_reg, m_len_next;

    farc_pkg::scan_flags_t         flags;
    logic [farc_pkg::STATUS_W-1:0] best_st;
    logic [IDXW-1:0]               win_idx;
    logic [AW-1:0]                 win_dist;
    logic [AW-1:0]                 best_base;
    logic [AW-1:0]                 best_len;
    logic [IDXW+IW-1:0]            win_idx_ext;

    assign s_tready    = (state_reg == farc_pkg::S_IDLE);
    assign in_fire     = s_tvalid && s_tready;
    assign last_issue  = (CW'(rd_idx_reg) + CW'(1)) == count_reg;
    assign win_idx_ext = {{IW{1'b0}}, win_idx};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= farc_pkg::S_IDLE;
            count_reg    <= '0;
            rd_idx_reg   <= '0;
            v0_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            rd_idx_reg   <= rd_idx_next;
            v0_reg       <= rd_en;
            m_tvalid_reg <= m_tvalid_next;
        end
        addr_reg     <= addr_next;
        idx0_reg     <= rd_idx_reg;
        m_status_reg <= m_status_next;
        m_index_reg  <= m_index_next;
        m_dist_reg   <= m_dist_next;
        m_base_reg   <= m_base_next;
        m_len_reg    <= m_len_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[count_reg[IDXW-1:0]] <= {s_tdata[127:64], s_tdata[63:0]};
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_idx_reg];
        end
    end

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        rd_idx_next   = rd_idx_reg;
        addr_next     = addr_reg;
        rd_en         = 1'b0;
        wr_en         = 1'b0;
        start         = 1'b0;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_status_next = m_status_reg;
        m_index_next  = m_index_reg;
        m_dist_next   = m_dist_reg;
        m_base_next   = m_base_reg;
        m_len_next    = m_len_reg;
        case (state_reg)
            farc_pkg::S_IDLE: begin
                if (in_fire) begin
                    case (s_tuser)
                        farc_pkg::KIND_CLEAR: begin
                            count_next = '0;
                        end
                        farc_pkg::KIND_TRACK: begin
                            if (count_reg < CW'(ENTRIES)) begin
                                wr_en      = 1'b1;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        farc_pkg::KIND_QUERY: begin
                            start       = 1'b1;
                            addr_next   = s_tdata[63:0];
                            rd_idx_next = '0;
                            state_next  = (count_reg == '0) ? farc_pkg::S_DONE
                                                            : farc_pkg::S_SCAN;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            farc_pkg::S_SCAN: begin
                rd_en = 1'b1;
                if (last_issue) begin
                    state_next = farc_pkg::S_DRAIN;
                end else begin
                    rd_idx_next = rd_idx_reg + IDXW'(1);
                end
            end
            farc_pkg::S_DRAIN: begin
                if (!v0_reg && !flags.busy) begin
                    state_next = farc_pkg::S_DONE;
                end
            end
            farc_pkg::S_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    state_next    = farc_pkg::S_IDLE;
                    if (count_reg == '0) begin
                        m_status_next = farc_pkg::ST_EMPTY;
                        m_index_next  = '0;
                        m_dist_next   = '0;
                        m_base_next   = '0;
                        m_len_next    = '0;
                    end else if (flags.found) begin
                        m_status_next = best_st;
                        m_index_next  = win_idx_ext[IW-1:0];
                        m_dist_next   = win_dist;
                        m_base_next   = best_base;
                        m_len_next    = best_len;
                    end else begin
                        m_status_next = farc_pkg::ST_NONE;
                        m_index_next  = '0;
                        m_dist_next   = '0;
                        m_base_next   = '0;
                        m_len_next    = '0;
                    end
                end
            end
            default: begin
                state_next = farc_pkg::S_IDLE;
            end
        endcase
    end

    farc_scan #(
        .IDXW(IDXW)
    ) u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (start),
        .in_valid  (v0_reg),
        .in_idx    (idx0_reg),
        .in_base   (rd_data_reg[AW-1:0]),
        .in_len    (rd_data_reg[2*AW-1:AW]),
        .addr      (addr_reg),
        .flags     (flags),
        .best_st   (best_st),
        .win_idx   (win_idx),
        .win_dist  (win_dist),
        .best_base (best_base),
        .best_len  (best_len)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {2'b00, m_len_reg, m_base_reg, m_dist_reg, m_index_reg};

endmodule

@@ rtl/core/farc_scan.sv @@
`timescale 1ns / 1ps

module farc_scan #(
    parameter int IDXW = 6
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic                                in_valid,
    input  logic [IDXW-1:0]                     in_idx,
    input  logic [farc_pkg::ADDR_W-1:0]         in_base,
    input  logic [farc_pkg::ADDR_W-1:0]         in_len,
    input  logic [farc_pkg::ADDR_W-1:0]         addr,
    output farc_pkg::scan_flags_t               flags,
    output logic [farc_pkg::STATUS_W-1:0]       best_st,
    output logic [IDXW-1:0]                     win_idx,
    output logic [farc_pkg::ADDR_W-1:0]         win_dist,
    output logic [farc_pkg::ADDR_W-1:0]         best_base,
    output logic [farc_pkg::ADDR_W-1:0]         best_len
);

    localparam int AW = farc_pkg::ADDR_W;

    // stage 1: region end and offset from base
    logic            v1_reg;
    logic [IDXW-1:0] idx1_reg;
    logic [AW-1:0]   b1_reg;
    logic [AW-1:0]   l1_reg;
    logic [AW-1:0]   end1_reg;
    logic [AW-1:0]   off1_reg;
    logic            ge_b1_reg;
    logic [AW:0]     off_wide;

    // stage 2: classification and gap
    logic                          v2_reg;
    logic [IDXW-1:0]               idx2_reg;
    logic [AW-1:0]                 b2_reg;
    logic [AW-1:0]                 l2_reg;
    logic                          inside2_reg;
    logic                          cand2_reg;
    logic [farc_pkg::STATUS_W-1:0] st2_reg;
    logic [AW-1:0]                 d2_reg;
    logic [AW:0]                   diff_end;
    logic                          ge_end;
    logic                          in_region;

    // stage 3: running best
    logic                          hit_reg;
    logic                          found_reg;
    logic [farc_pkg::STATUS_W-1:0] best_st_reg;
    logic [IDXW-1:0]               win_idx_reg;
    logic [AW-1:0]                 win_dist_reg;
    logic [AW-1:0]                 best_base_reg;
    logic [AW-1:0]                 best_len_reg;
    logic                          take_inside;
    logic                          take_near;

    assign off_wide = {1'b0, addr} - {1'b0, in_base};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else begin
            v1_reg <= in_valid;
        end
        idx1_reg  <= in_idx;
        b1_reg    <= in_base;
        l1_reg    <= in_len;
        end1_reg  <= in_base + in_len;
        off1_reg  <= off_wide[AW-1:0];
        ge_b1_reg <= ~off_wide[AW];
    end

    assign diff_end  = {1'b0, addr} - {1'b0, end1_reg};
    assign ge_end    = ~diff_end[AW];
    assign in_region = ge_b1_reg && !ge_end;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else begin
            v2_reg <= v1_reg;
        end
        idx2_reg    <= idx1_reg;
        b2_reg      <= b1_reg;
        l2_reg      <= l1_reg;
        inside2_reg <= in_region;
        cand2_reg   <= ge_end || !ge_b1_reg;
        if (in_region) begin
            st2_reg <= farc_pkg::ST_INSIDE;
            d2_reg  <= off1_reg;
        end else if (ge_end) begin
            st2_reg <= farc_pkg::ST_PAST;
            d2_reg  <= diff_end[AW-1:0];
        end else begin
            st2_reg <= farc_pkg::ST_BEFORE;
            d2_reg  <= {AW{1'b0}} - off1_reg;
        end
    end

    assign take_inside = v2_reg && !hit_reg && inside2_reg;
    assign take_near   = v2_reg && !hit_reg && !inside2_reg && cand2_reg &&
                         (d2_reg < win_dist_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_reg      <= 1'b0;
            found_reg    <= 1'b0;
            win_dist_reg <= {AW{1'b1}};
        end else if (start) begin
            hit_reg      <= 1'b0;
            found_reg    <= 1'b0;
            win_dist_reg <= {AW{1'b1}};
        end else if (take_inside || take_near) begin
            hit_reg      <= take_inside;
            found_reg    <= 1'b1;
            win_dist_reg <= d2_reg;
        end
        if (take_inside || take_near) begin
            best_st_reg   <= st2_reg;
            win_idx_reg   <= idx2_reg;
            best_base_reg <= b2_reg;
            best_len_reg  <= l2_reg;
        end
    end

    assign flags.busy  = v1_reg || v2_reg;
    assign flags.hit   = hit_reg;
    assign flags.found = found_reg;
    assign best_st     = best_st_reg;
    assign win_idx     = win_idx_reg;
    assign win_dist    = win_dist_reg;
    assign best_base   = best_base_reg;
    assign best_len    = best_len_reg;

endmodule

@@ sim/farc_match_checker.sv @@
`timescale 1ns / 1ps

module farc_match_checker
    import farc_pkg::*;
#(
    parameter int REGION_SLOTS = 64
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [127:0] s_tdata,   // address, region_size
    input  logic [1:0]   s_tuser,   // kind
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [199:0] m_tdata,   // entry_index, distance, entry_base, entry_length, zero pad
    input  logic [2:0]   m_tuser,   // status
    output int           mismatches,
    output int           pending_lookups,
    output int           lookups_checked
);

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [INDEX_W-1:0]  slot;
        logic [63:0]         gap;
        logic [63:0]         base;
        logic [63:0]         length;
    } fault_match_t;

    logic [63:0]  region_base [REGION_SLOTS];
    logic [63:0]  region_len  [REGION_SLOTS];
    int unsigned  region_cnt;
    fault_match_t expected_matches[$];
    int           mismatch_count;
    int           checked_count;

    initial begin
        region_cnt     = 0;
        mismatch_count = 0;
        checked_count  = 0;
        mismatches      = 0;
        pending_lookups = 0;
        lookups_checked = 0;
    end

    function automatic fault_match_t locate_fault(input logic [63:0] addr);
        fault_match_t        m;
        logic [63:0]         lo;
        logic [63:0]         hi;
        logic [63:0]         d;
        logic [63:0]         best_gap;
        int unsigned         best_slot;
        logic [STATUS_W-1:0] best_status;
        m = '0;
        m.status = ST_EMPTY;
        if (region_cnt == 0) return m;
        for (int unsigned i = 0; i < region_cnt; i++) begin
            lo = region_base[i];
            hi = lo + region_len[i];
            if (addr >= lo && addr < hi) begin
                m.status = ST_INSIDE;
                m.slot   = INDEX_W'(i);
                m.gap    = addr - lo;
                m.base   = lo;
                m.length = region_len[i];
                return m;
            end
        end
        // gap of all ones can never win
        best_gap    = '1;
        best_slot   = 0;
        best_status = ST_NONE;
        for (int unsigned i = 0; i < region_cnt; i++) begin
            lo = region_base[i];
            hi = lo + region_len[i];
            if (addr >= hi) begin
                d = addr - hi;
                if (d < best_gap) begin
                    best_gap = d;
                    best_slot = i;
                    best_status = ST_PAST;
                end
            end else if (addr < lo) begin
                d = lo - addr;
                if (d < best_gap) begin
                    best_gap = d;
                    best_slot = i;
                    best_status = ST_BEFORE;
                end
            end
        end
        m.status = best_status;
        if (best_status == ST_NONE) return m;
        m.slot   = INDEX_W'(best_slot);
        m.gap    = best_gap;
        m.base   = region_base[best_slot];
        m.length = region_len[best_slot];
        return m;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t ns: %s mismatch, got %h expected %h", $time, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge aclk) begin
        fault_match_t want;
        if (!aresetn) begin
            region_cnt = 0;
            expected_matches.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_matches.size() == 0) begin
                    report_mismatch("result with no lookup pending", 64'(m_tuser), 64'd0);
                end else begin
                    want = expected_matches.pop_front();
                    checked_count++;
                    if (m_tuser !== want.status)
                        report_mismatch("status", 64'(m_tuser), 64'(want.status));
                    if (m_tdata[5:0] !== want.slot)
                        report_mismatch("entry_index", 64'(m_tdata[5:0]), 64'(want.slot));
                    if (m_tdata[69:6] !== want.gap)
                        report_mismatch("distance", m_tdata[69:6], want.gap);
                    if (m_tdata[133:70] !== want.base)
                        report_mismatch("entry_base", m_tdata[133:70], want.base);
                    if (m_tdata[197:134] !== want.length)
                        report_mismatch("entry_length", m_tdata[197:134], want.length);
                end
            end
            if (s_tvalid && s_tready) begin
                case (s_tuser)
                    KIND_CLEAR: region_cnt = 0;
                    KIND_TRACK: begin
                        // full table drops the item
                        if (region_cnt < REGION_SLOTS) begin
                            region_base[region_cnt] = s_tdata[63:0];
                            region_len[region_cnt]  = s_tdata[127:64];
                            region_cnt++;
                        end
                    end
                    KIND_QUERY: expected_matches.push_back(locate_fault(s_tdata[63:0]));
                    default: ;
                endcase
            end
        end
        mismatches      <= mismatch_count;
        pending_lookups <= expected_matches.size();
        lookups_checked <= checked_count;
    end

endmodule

@@ sim/tb_fault_address_range_correlator_core.sv @@
`timescale 1ns / 1ps

module tb_fault_address_range_correlator_core;
    import farc_pkg::*;

    localparam int          TABLE_SLOTS = 64;
    localparam int          RUN_ITEMS   = 650;
    localparam int          CYCLE_LIMIT = 500000;
    localparam logic [1:0]  KIND_UNUSED = 2'd3;
    localparam logic [63:0] ALL_ONES    = 64'hFFFF_FFFF_FFFF_FFFF;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;   // address, region_size
    logic [1:0]   s_tuser;   // kind
    logic         m_tvalid;
    logic         m_tready;
    logic [199:0] m_tdata;   // entry_index, distance, entry_base, entry_length, zero pad
    logic [2:0]   m_tuser;   // status

    int mismatches;
    int pending_lookups;
    int lookups_checked;
    int cycle_count;
    int items_sent;
    int clears_sent;
    int tracks_sent;
    int tracks_dropped;
    int queries_sent;
    int unused_sent;

    logic [63:0] steer_base[$];
    logic [63:0] steer_size[$];
    int          table_fill;

    fault_address_range_correlator_core #(
        .ENTRIES (TABLE_SLOTS)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    farc_match_checker #(
        .REGION_SLOTS (TABLE_SLOTS)
    ) match_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .mismatches      (mismatches),
        .pending_lookups (pending_lookups),
        .lookups_checked (lookups_checked)
    );

    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial cycle_count = 0;
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic push_item(input logic [1:0] kind, input logic [63:0] addr,
                             input logic [63:0] size);
        int unsigned idle;
        idle = ((items_sent / 50) % 4 == 3) ? 0 : $urandom_range(0, 4);
        if (idle != 0) begin
            s_tvalid <= 1'b0;
            repeat (idle) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {size, addr};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        case (kind)
            KIND_CLEAR: clears_sent++;
            KIND_TRACK: tracks_sent++;
            KIND_QUERY: queries_sent++;
            default:    unused_sent++;
        endcase
        if (kind != KIND_UNUSED) items_sent++;
    endtask

    task automatic clear_table();
        push_item(KIND_CLEAR, rand64(), rand64());
        steer_base.delete();
        steer_size.delete();
        table_fill = 0;
    endtask

    task automatic track_region(input logic [63:0] base, input logic [63:0] size);
        push_item(KIND_TRACK, base, size);
        if (table_fill < TABLE_SLOTS) begin
            steer_base.push_back(base);
            steer_size.push_back(size);
            table_fill++;
        end else begin
            tracks_dropped++;
        end
    endtask

    function automatic logic [63:0] pick_region_base();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 4) return rand64();
        if (r < 9) return 64'h0000_7F00_0000_0000 + 64'($urandom_range(0, 1 << 20));
        return ALL_ONES - 64'($urandom_range(0, 8192));
    endfunction

    function automatic logic [63:0] pick_region_size();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0) return 64'd0;
        if (r == 1) return rand64();
        return 64'($urandom_range(1, 65536));
    endfunction

    function automatic logic [63:0] pick_fault_addr();
        int unsigned k;
        logic [63:0] b;
        logic [63:0] s;
        if (steer_base.size() == 0 || $urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 2))
                0:       return 64'd0;
                1:       return ALL_ONES;
                default: return rand64();
            endcase
        end
        k = $urandom_range(0, steer_base.size() - 1);
        b = steer_base[k];
        s = steer_size[k];
        case ($urandom_range(0, 6))
            0:       return (s == 0) ? b : b + (rand64() % s);
            1:       return b;
            2:       return b + s - 64'd1;
            3:       return b + s;
            4:       return b + s + 64'($urandom_range(1, 4096));
            5:       return b - 64'($urandom_range(1, 4096));
            default: return b + (rand64() % 64'h20000);
        endcase
    endfunction

    // result side: random hold-off per item but none in every third run of thirty, one long stall to back the block up
    initial begin
        int unsigned idle;
        int unsigned taken;
        taken = 0;
        m_tready = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (taken == 40)
                idle = 600;
            else if ((taken / 30) % 3 == 2)
                idle = 0;
            else
                idle = $urandom_range(0, 4);
            if (idle != 0) begin
                m_tready <= 1'b0;
                repeat (idle) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            taken++;
        end
    end

    initial begin
        int unsigned n_regions;
        int unsigned n_queries;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = KIND_CLEAR;
        items_sent = 0;
        clears_sent = 0;
        tracks_sent = 0;
        tracks_dropped = 0;
        queries_sent = 0;
        unused_sent = 0;
        table_fill = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty table, unused kind, extreme and wrapping regions, ties
        push_item(KIND_QUERY, 64'd0, ALL_ONES);
        push_item(KIND_QUERY, ALL_ONES, 64'd0);
        push_item(KIND_UNUSED, ALL_ONES, ALL_ONES);
        track_region(64'd0, 64'd0);
        push_item(KIND_QUERY, ALL_ONES, 64'd0);
        push_item(KIND_QUERY, 64'd0, 64'd0);
        track_region(ALL_ONES, ALL_ONES);
        track_region(64'h1000, 64'h100);
        track_region(64'h1000, 64'h100);
        track_region(ALL_ONES - 64'hF, 64'h20);
        push_item(KIND_QUERY, 64'h1080, 64'd0);
        push_item(KIND_QUERY, 64'h1100, 64'd0);
        push_item(KIND_QUERY, 64'h0FF0, 64'd0);
        push_item(KIND_QUERY, 64'h8, 64'd0);
        push_item(KIND_QUERY, ALL_ONES, 64'd0);
        push_item(KIND_QUERY, ALL_ONES - 64'h4, 64'd0);
        push_item(KIND_UNUSED, 64'd0, 64'd0);
        clear_table();
        push_item(KIND_QUERY, 64'h1080, 64'd0);

        while (items_sent < RUN_ITEMS) begin
            if ($urandom_range(0, 9) != 0) clear_table();
            n_regions = ($urandom_range(0, 99) < 88) ? $urandom_range(1, 8)
                                                     : $urandom_range(60, 70);
            for (int unsigned i = 0; i < n_regions; i++) begin
                track_region(pick_region_base(), pick_region_size());
                if ($urandom_range(0, 29) == 0) push_item(KIND_UNUSED, rand64(), rand64());
            end
            n_queries = $urandom_range(2, 8);
            for (int unsigned i = 0; i < n_queries; i++)
                push_item(KIND_QUERY, pick_fault_addr(), rand64());
        end

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_lookups != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);

        $display("covered %0d clears, %0d tracks (%0d dropped on a full table), %0d unused kinds",
                 clears_sent, tracks_sent, tracks_dropped, unused_sent);
        $display("%0d fault lookups sent, %0d results compared field by field",
                 queries_sent, lookups_checked);
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/farc_pkg.sv
rtl/core/farc_scan.sv
rtl/core/fault_address_range_correlator_core.sv
sim/farc_match_checker.sv
sim/tb_fault_address_range_correlator_core.sv
